// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL; only the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define NPS_ASSERT_NEXT(lbl, trig, cond) \
    `NPS_ASSERT(lbl, trig |=> cond)
`else
`define NPS_ASSERT(lbl, prop)
`define NPS_ASSERT_NEXT(lbl, trig, cond)
`endif
`endif

// ===== rtl/nps_pkg.sv =====
package nps_pkg;

    localparam int COORD_BITS      = 12;
    localparam int MAX_HALF_LENGTH = 15;
    localparam int QF              = 14;
    localparam int STEP_FRAC       = 4;
    localparam int WALK_LIMIT      = 8192;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int SIZE_W     = 13;

    localparam int VEC_W      = 17;     // edge vectors and the raw normal
    localparam int SQ_W       = 60;     // radicand (x*x+y*y) << 28
    localparam int ROOT_W     = 31;
    localparam int DIV_STEPS  = 16;     // quotient bits, unit components stay below 2^16
    localparam int DIV_W      = VEC_W + 2 * QF;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int UNIT_W     = 16;
    localparam int ACC_W      = 40;
    localparam int PT_W       = 24;
    localparam int J_W        = $clog2(WALK_LIMIT + 1) + 1;
    localparam int CNT_W      = 5;      // walk count, up to 16 for the centre offset
    localparam int HL_W       = 4;
    localparam int IDX_W      = $clog2(MAX_HALF_LENGTH + 1);
    localparam int POS_W      = $clog2(2 * MAX_HALF_LENGTH + 1);
    localparam int STEP_CNT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PYRAMID_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd5;

    typedef logic [COORD_BITS-1:0]   t_coord;
    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic [VEC_W-1:0]        t_mag;
    typedef logic [SQ_W-1:0]         t_sq;
    typedef logic [ROOT_W-1:0]       t_root;
    typedef logic [DIV_W-1:0]        t_div;
    typedef logic signed [UNIT_W-1:0] t_unit;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [ACC_W-1:0]        t_uacc;
    typedef logic signed [PT_W-1:0]  t_pt;
    typedef logic [J_W-1:0]          t_j;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [STEP_CNT_W-1:0]   t_step;
    typedef logic signed [IDX_W:0]   t_i;
    typedef logic [POS_W-1:0]        t_pos;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SQ_X,
        CMD_SQ_Y,
        CMD_SQRT,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_DIV_END_X,
        CMD_DIV_END_Y,
        CMD_SAVE_A,
        CMD_SAVE_B,
        CMD_SAVE_D,
        CMD_WOFF_INIT,
        CMD_WALK_STEP,
        CMD_WOFF_SAVE,
        CMD_WSMP_INIT,
        CMD_EMIT_INIT,
        CMD_EMIT
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQRT,
        S_DIVX_INIT,
        S_DIVX,
        S_DIVX_END,
        S_DIVY,
        S_DIVY_END,
        S_SAVE,
        S_WOFF_INIT,
        S_WOFF,
        S_WSMP_INIT,
        S_WSMP,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_N
    } t_phase;

    typedef struct packed {
        logic walk_done;
        logic out_free;
        logic emit_last;
    } t_status;

    function automatic t_mag abs_vec(input t_vec v);
        t_vec n;
        n = -v;
        return v[VEC_W-1] ? t_mag'(n) : t_mag'(v);
    endfunction

    // round to nearest, ties to even, on the magnitude
    function automatic t_pt rne_shift(input t_acc v, input logic wide);
        t_uacc mag;
        t_uacc q;
        t_uacc rem;
        t_uacc half;
        t_uacc one;
        int unsigned sh;
        t_pt qs;
        one  = t_uacc'(1);
        sh   = wide ? (QF + STEP_FRAC) : QF;
        mag  = v[ACC_W-1] ? t_uacc'(-v) : t_uacc'(v);
        q    = mag >> sh;
        rem  = mag & ((one << sh) - one);
        half = one << (sh - 1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + one;
        end
        qs = t_pt'(q);
        return v[ACC_W-1] ? -qs : qs;
    endfunction

    function automatic t_coord clamp_coord(input t_pt v, input logic [SIZE_W-1:0] size,
                                           input logic [1:0] lvl);
        logic [SIZE_W-1:0] lim;
        t_pt lim_s;
        lim = size >> lvl;
        if (lim == '0) begin
            lim = SIZE_W'(1);
        end
        lim = lim - SIZE_W'(1);
        if (lim > SIZE_W'((1 << COORD_BITS) - 1)) begin
            lim = SIZE_W'((1 << COORD_BITS) - 1);
        end
        lim_s = t_pt'(lim);
        if (v < 0) begin
            return '0;
        end else if (v > lim_s) begin
            return t_coord'(lim_s);
        end else begin
            return t_coord'(v);
        end
    endfunction

endpackage

// ===== rtl/normal_profile_sampler_unit.sv =====
// From request to first sample: three normalizations (each a 30-step square root and two
// 16-step divisions), then one cycle per walk step for the center offset (about 1.4 steps
// per point, up to ~23) and for the samples (about 23*k/step_size steps, a few hundred at
// the finest step).
// Throughput: one landmark at a time; samples leave at one per cycle while the output is not
// stalled, 2k+1 in all. The next request is taken once the last sample sits in the output
// register. Reset (synchronous, active low) clears the controller and output valid and loads
// the register defaults.
`include "assert_macros.svh"

module normal_profile_sampler_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  nps_pkg::t_coord                i_center_x,
    input  nps_pkg::t_coord                i_center_y,
    input  nps_pkg::t_coord                i_prev_x,
    input  nps_pkg::t_coord                i_prev_y,
    input  nps_pkg::t_coord                i_next_x,
    input  nps_pkg::t_coord                i_next_y,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output nps_pkg::t_coord                o_sample_x,
    output nps_pkg::t_coord                o_sample_y,
    output nps_pkg::t_pos                  o_sample_index,
    output logic                           o_last
);

    nps_pkg::t_cmd    cmd;
    nps_pkg::t_status status;
    logic             busy;

    nps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    nps_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_prev_x       (i_prev_x),
        .i_prev_y       (i_prev_y),
        .i_next_x       (i_next_x),
        .i_next_y       (i_next_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_x     (o_sample_x),
        .o_sample_y     (o_sample_y),
        .o_sample_index (o_sample_index),
        .o_last         (o_last)
    );

    assign o_in_stall = busy;

    `NPS_ASSERT_NEXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall)
    `NPS_ASSERT(a_last_at_zero, o_out_valid && o_last |-> o_sample_index == '0)
    `NPS_ASSERT_NEXT(a_index_down, o_out_valid && !i_out_stall && !o_last, !o_out_valid || (o_sample_index == $past(o_sample_index) - 5'd1))

endmodule

// ===== rtl/nps_ctrl.sv =====
module nps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  nps_pkg::t_status i_status,
    output nps_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    nps_pkg::t_state r_state, n_state;
    nps_pkg::t_phase r_phase, n_phase;
    nps_pkg::t_step  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nps_pkg::S_IDLE;
            r_phase <= nps_pkg::PH_A;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        o_cmd   = nps_pkg::CMD_NONE;
        o_busy  = (r_state != nps_pkg::S_IDLE);
        unique case (r_state)
            nps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = nps_pkg::CMD_LOAD;
                    n_phase = nps_pkg::PH_A;
                    n_state = nps_pkg::S_SQ_X;
                end
            end
            nps_pkg::S_SQ_X: begin
                o_cmd   = nps_pkg::CMD_SQ_X;
                n_state = nps_pkg::S_SQ_Y;
            end
            nps_pkg::S_SQ_Y: begin
                o_cmd   = nps_pkg::CMD_SQ_Y;
                n_cnt   = '0;
                n_state = nps_pkg::S_SQRT;
            end
            nps_pkg::S_SQRT: begin
                o_cmd = nps_pkg::CMD_SQRT;
                if (r_cnt == nps_pkg::t_step'(nps_pkg::SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = nps_pkg::S_DIVX_INIT;
                end else begin
                    n_cnt = r_cnt + nps_pkg::t_step'(1);
                end
            end
            nps_pkg::S_DIVX_INIT: begin
                o_cmd   = nps_pkg::CMD_DIV_INIT;
                n_state = nps_pkg::S_DIVX;
            end
            nps_pkg::S_DIVX, nps_pkg::S_DIVY: begin
                o_cmd = nps_pkg::CMD_DIV_STEP;
                if (r_cnt == nps_pkg::t_step'(nps_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = (r_state == nps_pkg::S_DIVX) ? nps_pkg::S_DIVX_END
                                                           : nps_pkg::S_DIVY_END;
                end else begin
                    n_cnt = r_cnt + nps_pkg::t_step'(1);
                end
            end
            nps_pkg::S_DIVX_END: begin
                o_cmd   = nps_pkg::CMD_DIV_END_X;
                n_state = nps_pkg::S_DIVY;
            end
            nps_pkg::S_DIVY_END: begin
                o_cmd   = nps_pkg::CMD_DIV_END_Y;
                n_state = nps_pkg::S_SAVE;
            end
            nps_pkg::S_SAVE: begin
                unique case (r_phase)
                    nps_pkg::PH_A: begin
                        o_cmd   = nps_pkg::CMD_SAVE_A;
                        n_phase = nps_pkg::PH_B;
                        n_state = nps_pkg::S_SQ_X;
                    end
                    nps_pkg::PH_B: begin
                        o_cmd   = nps_pkg::CMD_SAVE_B;
                        n_phase = nps_pkg::PH_N;
                        n_state = nps_pkg::S_SQ_X;
                    end
                    default: begin
                        o_cmd   = nps_pkg::CMD_SAVE_D;
                        n_state = nps_pkg::S_WOFF_INIT;
                    end
                endcase
            end
            nps_pkg::S_WOFF_INIT: begin
                o_cmd   = nps_pkg::CMD_WOFF_INIT;
                n_state = nps_pkg::S_WOFF;
            end
            nps_pkg::S_WOFF: begin
                if (i_status.walk_done) begin
                    o_cmd   = nps_pkg::CMD_WOFF_SAVE;
                    n_state = nps_pkg::S_WSMP_INIT;
                end else begin
                    o_cmd = nps_pkg::CMD_WALK_STEP;
                end
            end
            nps_pkg::S_WSMP_INIT: begin
                o_cmd   = nps_pkg::CMD_WSMP_INIT;
                n_state = nps_pkg::S_WSMP;
            end
            nps_pkg::S_WSMP: begin
                if (i_status.walk_done) begin
                    o_cmd   = nps_pkg::CMD_EMIT_INIT;
                    n_state = nps_pkg::S_EMIT;
                end else begin
                    o_cmd = nps_pkg::CMD_WALK_STEP;
                end
            end
            nps_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd = nps_pkg::CMD_EMIT;
                    if (i_status.emit_last) begin
                        n_state = nps_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = nps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/nps_datapath.sv =====
module nps_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nps_pkg::t_cmd                      i_cmd,
    output nps_pkg::t_status                   o_status,
    input  logic                               i_cfg_we,
    input  logic [nps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  nps_pkg::t_coord                    i_center_x,
    input  nps_pkg::t_coord                    i_center_y,
    input  nps_pkg::t_coord                    i_prev_x,
    input  nps_pkg::t_coord                    i_prev_y,
    input  nps_pkg::t_coord                    i_next_x,
    input  nps_pkg::t_coord                    i_next_y,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output nps_pkg::t_coord                    o_sample_x,
    output nps_pkg::t_coord                    o_sample_y,
    output nps_pkg::t_pos                      o_sample_index,
    output logic                               o_last
);

    // configuration
    logic [nps_pkg::HL_W-1:0]   r_half_length;
    logic [7:0]                 r_step_size;
    logic signed [4:0]          r_center_offset;
    logic [1:0]                 r_pyramid_level;
    logic [nps_pkg::SIZE_W-1:0] r_image_width;
    logic [nps_pkg::SIZE_W-1:0] r_image_height;

    // landmark and vectors
    nps_pkg::t_coord r_cx, r_cy, r_nxi, r_nyi;
    nps_pkg::t_vec   r_vx, r_vy;
    nps_pkg::t_unit  r_uax, r_uay, r_resx, r_resy, r_dx, r_dy;
    logic [2*nps_pkg::VEC_W-1:0] r_s;
    logic            r_zero;

    // square root and divider
    nps_pkg::t_sq    r_rad, r_root, r_bit;
    nps_pkg::t_root  r_rem;
    logic [nps_pkg::DIV_STEPS-1:0] r_dlo, r_q;

    // walker
    nps_pkg::t_acc   r_accx, r_accy, r_incx, r_incy;
    logic            r_wide;
    nps_pkg::t_j     r_j;
    nps_pkg::t_cnt   r_wcnt, r_wn;
    nps_pkg::t_pt    r_px, r_py, r_ox, r_oy, r_bx, r_by;
    nps_pkg::t_pt    r_arrx [nps_pkg::MAX_HALF_LENGTH+1];
    nps_pkg::t_pt    r_arry [nps_pkg::MAX_HALF_LENGTH+1];

    // emission
    nps_pkg::t_i     r_i;
    logic            r_out_valid;
    nps_pkg::t_coord r_sx, r_sy;
    nps_pkg::t_pos   r_sidx;
    logic            r_last;

    logic [nps_pkg::HL_W-1:0] k_eff;
    logic [7:0]               st_eff;
    nps_pkg::t_cnt            off_mag;
    nps_pkg::t_mag            mag_x, mag_y;
    logic [2*nps_pkg::VEC_W:0] s_sum;
    nps_pkg::t_sq             sq_rb;
    logic                     sq_ge;
    nps_pkg::t_root           m_val;
    logic [nps_pkg::ROOT_W:0] dv_t, dv_m, dv_rem2;
    logic                     dv_ge, dv_up;
    logic [nps_pkg::DIV_STEPS:0] dv_qr;
    nps_pkg::t_unit           dv_u;
    nps_pkg::t_div            dv_nx, dv_ny;
    nps_pkg::t_pt             w_rx, w_ry;
    logic                     w_new;
    nps_pkg::t_cnt            w_cnt_nx;
    logic signed [nps_pkg::UNIT_W+8:0] prodx, prody;
    nps_pkg::t_i              k_neg, i_neg;
    logic [nps_pkg::IDX_W-1:0] i_mag;
    nps_pkg::t_pt             e_px, e_py, e_sx, e_sy;
    logic signed [nps_pkg::IDX_W+1:0] e_pos;
    logic                     out_free;

    always_comb begin
        k_eff   = (r_half_length > nps_pkg::HL_W'(nps_pkg::MAX_HALF_LENGTH))
                  ? nps_pkg::HL_W'(nps_pkg::MAX_HALF_LENGTH) : r_half_length;
        st_eff  = (r_step_size == 8'd0) ? 8'd1 : r_step_size;
        off_mag = r_center_offset[4] ? nps_pkg::t_cnt'(-r_center_offset)
                                     : nps_pkg::t_cnt'(r_center_offset);
        mag_x   = nps_pkg::abs_vec(r_vx);
        mag_y   = nps_pkg::abs_vec(r_vy);
        s_sum   = {1'b0, r_s} + (2*nps_pkg::VEC_W+1)'(mag_y * mag_y);

        sq_rb   = r_root + r_bit;
        sq_ge   = (r_rad >= sq_rb);

        m_val   = nps_pkg::t_root'(r_root);
        dv_m    = {1'b0, m_val};
        dv_t    = {r_rem, r_dlo[nps_pkg::DIV_STEPS-1]};
        dv_ge   = (dv_t >= dv_m);
        dv_rem2 = {r_rem, 1'b0};
        dv_up   = (dv_rem2 > dv_m) || ((dv_rem2 == dv_m) && r_q[0]);
        dv_qr   = {1'b0, r_q} + (nps_pkg::DIV_STEPS+1)'(dv_up);
        dv_u    = r_zero ? '0 : nps_pkg::t_unit'(dv_qr);
        dv_nx   = nps_pkg::t_div'(mag_x) << (2 * nps_pkg::QF);
        dv_ny   = nps_pkg::t_div'(mag_y) << (2 * nps_pkg::QF);

        w_rx     = nps_pkg::rne_shift(r_accx, r_wide);
        w_ry     = nps_pkg::rne_shift(r_accy, r_wide);
        w_new    = (w_rx != r_px) || (w_ry != r_py);
        w_cnt_nx = r_wcnt + nps_pkg::t_cnt'(1);
        prodx    = r_dx * $signed({1'b0, st_eff});
        prody    = r_dy * $signed({1'b0, st_eff});

        k_neg = -nps_pkg::t_i'({1'b0, k_eff});
        i_neg = -r_i;
        i_mag = r_i[nps_pkg::IDX_W] ? i_neg[nps_pkg::IDX_W-1:0] : r_i[nps_pkg::IDX_W-1:0];
        if (i_mag == '0) begin
            e_px = '0;
            e_py = '0;
        end else if (nps_pkg::t_cnt'(i_mag) <= r_wcnt) begin
            e_px = r_arrx[i_mag];
            e_py = r_arry[i_mag];
        end else begin
            // walk ran out: missing points repeat the last one found
            e_px = r_px;
            e_py = r_py;
        end
        if (r_i[nps_pkg::IDX_W]) begin
            e_px = -e_px;
            e_py = -e_py;
        end
        e_sx  = r_bx + e_px;
        e_sy  = r_by + e_py;
        e_pos = (nps_pkg::IDX_W+2)'(r_i) + $signed({2'b00, k_eff});
        out_free = !r_out_valid || !i_out_stall;
    end

    assign o_status.walk_done = !((r_wcnt < r_wn) &&
                                  (r_j <= nps_pkg::t_j'(nps_pkg::WALK_LIMIT)));
    assign o_status.out_free  = out_free;
    assign o_status.emit_last = (r_i == k_neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_length   <= 4'd4;
            r_step_size     <= 8'd32;
            r_center_offset <= 5'sd0;
            r_pyramid_level <= 2'd0;
            r_image_width   <= 13'd640;
            r_image_height  <= 13'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nps_pkg::CFG_HALF_LENGTH:   r_half_length   <= i_cfg_data[3:0];
                nps_pkg::CFG_STEP_SIZE:     r_step_size     <= i_cfg_data[7:0];
                nps_pkg::CFG_CENTER_OFFSET: r_center_offset <= $signed(i_cfg_data[4:0]);
                nps_pkg::CFG_PYRAMID_LEVEL: r_pyramid_level <= i_cfg_data[1:0];
                nps_pkg::CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data;
                nps_pkg::CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == nps_pkg::CMD_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            nps_pkg::CMD_NONE: ;
            nps_pkg::CMD_LOAD: begin
                r_cx  <= i_center_x;
                r_cy  <= i_center_y;
                r_nxi <= i_next_x;
                r_nyi <= i_next_y;
                r_vx  <= nps_pkg::t_vec'({1'b0, i_prev_x}) - nps_pkg::t_vec'({1'b0, i_center_x});
                r_vy  <= nps_pkg::t_vec'({1'b0, i_prev_y}) - nps_pkg::t_vec'({1'b0, i_center_y});
            end
            nps_pkg::CMD_SQ_X: begin
                r_s <= mag_x * mag_x;
            end
            nps_pkg::CMD_SQ_Y: begin
                r_zero <= (s_sum == '0);
                r_rad  <= nps_pkg::t_sq'(s_sum) << (2 * nps_pkg::QF);
                r_root <= '0;
                r_bit  <= nps_pkg::t_sq'(1) << (nps_pkg::SQ_W - 2);
            end
            nps_pkg::CMD_SQRT: begin
                if (sq_ge) begin
                    r_rad  <= r_rad - sq_rb;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            nps_pkg::CMD_DIV_INIT: begin
                r_rem <= nps_pkg::t_root'(dv_nx[nps_pkg::DIV_W-1:nps_pkg::DIV_STEPS]);
                r_dlo <= dv_nx[nps_pkg::DIV_STEPS-1:0];
                r_q   <= '0;
            end
            nps_pkg::CMD_DIV_STEP: begin
                r_rem <= dv_ge ? nps_pkg::t_root'(dv_t - dv_m) : nps_pkg::t_root'(dv_t);
                r_dlo <= r_dlo << 1;
                r_q   <= {r_q[nps_pkg::DIV_STEPS-2:0], dv_ge};
            end
            nps_pkg::CMD_DIV_END_X: begin
                r_resx <= r_vx[nps_pkg::VEC_W-1] ? -dv_u : dv_u;
                r_rem  <= nps_pkg::t_root'(dv_ny[nps_pkg::DIV_W-1:nps_pkg::DIV_STEPS]);
                r_dlo  <= dv_ny[nps_pkg::DIV_STEPS-1:0];
                r_q    <= '0;
            end
            nps_pkg::CMD_DIV_END_Y: begin
                r_resy <= r_vy[nps_pkg::VEC_W-1] ? -dv_u : dv_u;
            end
            nps_pkg::CMD_SAVE_A: begin
                r_uax <= r_resx;
                r_uay <= r_resy;
                r_vx  <= nps_pkg::t_vec'({1'b0, r_nxi}) - nps_pkg::t_vec'({1'b0, r_cx});
                r_vy  <= nps_pkg::t_vec'({1'b0, r_nyi}) - nps_pkg::t_vec'({1'b0, r_cy});
            end
            nps_pkg::CMD_SAVE_B: begin
                r_vx <= nps_pkg::t_vec'(r_resy) - nps_pkg::t_vec'(r_uay);
                r_vy <= nps_pkg::t_vec'(r_uax) - nps_pkg::t_vec'(r_resx);
            end
            nps_pkg::CMD_SAVE_D: begin
                // zero normal: fall back to -ua, or to +x when ua is zero too
                if (r_vx == '0 && r_vy == '0) begin
                    if (r_uax != '0 || r_uay != '0) begin
                        r_dx <= -r_uax;
                        r_dy <= -r_uay;
                    end else begin
                        r_dx <= nps_pkg::t_unit'(1 << nps_pkg::QF);
                        r_dy <= '0;
                    end
                end else begin
                    r_dx <= r_resx;
                    r_dy <= r_resy;
                end
            end
            nps_pkg::CMD_WOFF_INIT: begin
                r_incx <= nps_pkg::t_acc'(r_dx);
                r_incy <= nps_pkg::t_acc'(r_dy);
                r_accx <= nps_pkg::t_acc'(r_dx);
                r_accy <= nps_pkg::t_acc'(r_dy);
                r_wide <= 1'b0;
                r_wn   <= off_mag;
                r_j    <= nps_pkg::t_j'(1);
                r_wcnt <= '0;
                r_px   <= '0;
                r_py   <= '0;
            end
            nps_pkg::CMD_WALK_STEP: begin
                if (w_new) begin
                    r_wcnt <= w_cnt_nx;
                    r_px   <= w_rx;
                    r_py   <= w_ry;
                    if (r_wide) begin
                        r_arrx[w_cnt_nx[nps_pkg::IDX_W-1:0]] <= w_rx;
                        r_arry[w_cnt_nx[nps_pkg::IDX_W-1:0]] <= w_ry;
                    end
                end
                r_accx <= r_accx + r_incx;
                r_accy <= r_accy + r_incy;
                r_j    <= r_j + nps_pkg::t_j'(1);
            end
            nps_pkg::CMD_WOFF_SAVE: begin
                r_ox <= (r_center_offset > 0) ? r_px : -r_px;
                r_oy <= (r_center_offset > 0) ? r_py : -r_py;
            end
            nps_pkg::CMD_WSMP_INIT: begin
                r_incx <= nps_pkg::t_acc'(prodx);
                r_incy <= nps_pkg::t_acc'(prody);
                r_accx <= nps_pkg::t_acc'(prodx);
                r_accy <= nps_pkg::t_acc'(prody);
                r_wide <= 1'b1;
                r_wn   <= nps_pkg::t_cnt'(k_eff);
                r_j    <= nps_pkg::t_j'(1);
                r_wcnt <= '0;
                r_px   <= '0;
                r_py   <= '0;
            end
            nps_pkg::CMD_EMIT_INIT: begin
                r_i  <= nps_pkg::t_i'({1'b0, k_eff});
                r_bx <= nps_pkg::t_pt'(r_cx >> r_pyramid_level) + r_ox;
                r_by <= nps_pkg::t_pt'(r_cy >> r_pyramid_level) + r_oy;
            end
            nps_pkg::CMD_EMIT: begin
                r_sx   <= nps_pkg::clamp_coord(e_sx, r_image_width, r_pyramid_level);
                r_sy   <= nps_pkg::clamp_coord(e_sy, r_image_height, r_pyramid_level);
                r_sidx <= e_pos[nps_pkg::POS_W-1:0];
                r_last <= (r_i == k_neg);
                r_i    <= r_i - nps_pkg::t_i'(1);
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_x     = r_sx;
    assign o_sample_y     = r_sy;
    assign o_sample_index = r_sidx;
    assign o_last         = r_last;

endmodule

// ===== bench/tb_normal_profile_sampler_unit.sv =====
`timescale 1ns / 100ps

module tb_normal_profile_sampler_unit;
    import nps_pkg::*;

    typedef struct {
        t_coord x;
        t_coord y;
        t_pos   idx;
        logic   last;
    } sample_t;

    typedef struct {
        t_coord c[6];
        logic   typed;
        t_coord ex;
        t_coord ey;
    } landmark_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_coord                i_center_x, i_center_y, i_prev_x, i_prev_y, i_next_x, i_next_y;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_coord                o_sample_x, o_sample_y;
    t_pos                  o_sample_index;
    logic                  o_last;

    normal_profile_sampler_unit u_top (.*);

    sample_t       expected_samples[$];
    int            mismatch_count;
    int            landmark_count;
    int            sample_count;
    bit            hold_req;
    bit            burst_mode;

    // shadow registers
    int            sh_half, sh_step, sh_offset, sh_level, sh_width, sh_height;
    longint        pt_x[0:32];
    longint        pt_y[0:32];
    landmark_row_t landmark_table[10];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timeout with %0d samples outstanding", expected_samples.size());
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (sample %0d)", what, got, want,
                 sample_count);
        mismatch_count++;
    endtask

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned div_nearest_even(input longint unsigned n,
                                                         input longint unsigned d);
        longint unsigned q, r;
        q = n / d;
        r = n % d;
        if (2 * r > d || (2 * r == d && q[0])) q++;
        return q;
    endfunction

    function automatic longint shift_nearest_even(input longint v, input int sh);
        longint unsigned mag, q, r, half;
        mag  = v < 0 ? -v : v;
        q    = mag >> sh;
        r    = mag & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (r > half || (r == half && q[0])) q++;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    task automatic unit_vector(input longint x, input longint y,
                               output longint ux, output longint uy);
        longint unsigned mx, my, s, m;
        mx = x < 0 ? -x : x;
        my = y < 0 ? -y : y;
        s  = mx * mx + my * my;
        if (s == 0) begin
            ux = 0;
            uy = 0;
        end else begin
            m  = isqrt(s << 28);
            ux = longint'(div_nearest_even(mx << 28, m));
            uy = longint'(div_nearest_even(my << 28, m));
            if (x < 0) ux = -ux;
            if (y < 0) uy = -uy;
        end
    endtask

    // distinct rounded points along (dx,dy), repeated if the walk runs out
    task automatic walk_points(input longint dx, input longint dy, input int sh, input int n);
        int     found;
        longint j, x, y;
        found   = 0;
        j       = 1;
        pt_x[0] = 0;
        pt_y[0] = 0;
        while (found < n && j <= WALK_LIMIT) begin
            x = shift_nearest_even(j * dx, sh);
            y = shift_nearest_even(j * dy, sh);
            if (x != pt_x[found] || y != pt_y[found]) begin
                found++;
                pt_x[found] = x;
                pt_y[found] = y;
            end
            j++;
        end
        for (int i = found + 1; i <= n; i++) begin
            pt_x[i] = pt_x[found];
            pt_y[i] = pt_y[found];
        end
    endtask

    function automatic t_coord clamp_to_image(input longint v, input int size, input int lvl);
        longint lim;
        lim = size >> lvl;
        if (lim == 0) lim = 1;
        lim -= 1;
        if (lim > (1 << COORD_BITS) - 1) lim = (1 << COORD_BITS) - 1;
        if (v < 0) v = 0;
        if (v > lim) v = lim;
        return t_coord'(v);
    endfunction

    task automatic predict_profile(input t_coord c[6]);
        longint  ax, ay, bx, by, nx, ny, dx, dy, ox, oy, basex, basey, px, py;
        int      n, k, st;
        sample_t s;
        unit_vector(longint'(c[2]) - c[0], longint'(c[3]) - c[1], ax, ay);
        unit_vector(longint'(c[4]) - c[0], longint'(c[5]) - c[1], bx, by);
        nx = by - ay;
        ny = ax - bx;
        if (nx == 0 && ny == 0) begin
            if (ax != 0 || ay != 0) begin
                dx = -ax;
                dy = -ay;
            end else begin
                dx = 1 << QF;
                dy = 0;
            end
        end else begin
            unit_vector(nx, ny, dx, dy);
        end
        n = sh_offset < 0 ? -sh_offset : sh_offset;
        walk_points(dx, dy, QF, n);
        ox = sh_offset > 0 ? pt_x[n] : -pt_x[n];
        oy = sh_offset > 0 ? pt_y[n] : -pt_y[n];
        k  = sh_half > MAX_HALF_LENGTH ? MAX_HALF_LENGTH : sh_half;
        st = sh_step == 0 ? 1 : sh_step;
        walk_points(dx * st, dy * st, QF + STEP_FRAC, k);
        basex = (longint'(c[0]) >> sh_level) + ox;
        basey = (longint'(c[1]) >> sh_level) + oy;
        for (int i = k; i >= -k; i--) begin
            px     = i >= 0 ? pt_x[i] : -pt_x[-i];
            py     = i >= 0 ? pt_y[i] : -pt_y[-i];
            s.x    = clamp_to_image(basex + px, sh_width, sh_level);
            s.y    = clamp_to_image(basey + py, sh_height, sh_level);
            s.idx  = t_pos'(i + k);
            s.last = (i == -k);
            expected_samples.push_back(s);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        case (idx)
            CFG_HALF_LENGTH:   sh_half   = v[3:0];
            CFG_STEP_SIZE:     sh_step   = v[7:0];
            CFG_CENTER_OFFSET: sh_offset = $signed(v[4:0]);
            CFG_PYRAMID_LEVEL: sh_level  = v[1:0];
            CFG_IMAGE_WIDTH:   sh_width  = v;
            CFG_IMAGE_HEIGHT:  sh_height = v;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_config(input int k, input int st, input int off, input int lvl,
                               input int w, input int h);
        write_reg(CFG_HALF_LENGTH, k);
        write_reg(CFG_STEP_SIZE, st);
        write_reg(CFG_CENTER_OFFSET, off);
        write_reg(CFG_PYRAMID_LEVEL, lvl);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic wait_drained();
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // presents one request and returns the index of its first expected sample
    task automatic send_landmark(input t_coord c[6], output int first);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_center_x <= c[0];
        i_center_y <= c[1];
        i_prev_x   <= c[2];
        i_prev_y   <= c[3];
        i_next_x   <= c[4];
        i_next_y   <= c[5];
        do @(posedge i_clk); while (o_in_stall);
        first = expected_samples.size();
        predict_profile(c);
        landmark_count++;
    endtask

    task automatic sender_gap();
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_coord near(input t_coord c, input int spread);
        int v;
        v = int'(c) + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return t_coord'(v);
    endfunction

    task automatic random_landmark(output t_coord c[6]);
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++) c[i] = t_coord'($urandom);
        if (kind < 7) begin
            c[2] = near(c[0], 64);
            c[3] = near(c[1], 64);
            c[4] = near(c[0], 64);
            c[5] = near(c[1], 64);
        end else if (kind == 7) begin
            c[2] = c[0];
            c[3] = c[1];
        end else if (kind == 8) begin
            c[4] = c[2];
            c[5] = c[3];
        end
    endtask

    // receiver: random stalls per sample, zero-stall bursts, one long hold-off
    initial begin
        int w;
        int calm;
        i_out_stall = 1'b1;
        calm        = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                w        = 600;
                hold_req = 0;
            end else if (calm > 0) begin
                w = 0;
                calm--;
            end else begin
                w = $urandom_range(0, 8);
                if ($urandom_range(0, 40) == 0) calm = 40;
            end
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        sample_t s;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                $display("unexpected sample x=%0d y=%0d idx=%0d", o_sample_x, o_sample_y,
                         o_sample_index);
                mismatch_count++;
            end else begin
                s = expected_samples.pop_front();
                if (o_sample_x !== s.x) report_mismatch("sample_x", o_sample_x, s.x);
                if (o_sample_y !== s.y) report_mismatch("sample_y", o_sample_y, s.y);
                if (o_sample_index !== s.idx) report_mismatch("index", o_sample_index, s.idx);
                if (o_last !== s.last) report_mismatch("last", o_last, s.last);
            end
            sample_count++;
        end
    end

    initial begin
        t_coord c[6];
        int     first;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        {i_center_x, i_center_y, i_prev_x, i_prev_y, i_next_x, i_next_y} = '0;
        mismatch_count = 0;
        landmark_count = 0;
        sample_count   = 0;
        hold_req       = 0;
        burst_mode     = 0;
        sh_half = 4; sh_step = 32; sh_offset = 0; sh_level = 0; sh_width = 640; sh_height = 480;

        // typed rows: coincident points fall back to +x, step 2 px, k = 4
        landmark_table[0] = '{'{100, 100, 100, 100, 100, 100}, 1, 108, 100};
        landmark_table[1] = '{'{0, 0, 0, 0, 0, 0}, 1, 8, 0};
        landmark_table[2] = '{'{4095, 4095, 4095, 4095, 4095, 4095}, 1, 639, 479};
        landmark_table[3] = '{'{100, 100, 90, 100, 110, 100}, 0, 0, 0};    // straight edge
        landmark_table[4] = '{'{100, 100, 110, 100, 110, 100}, 0, 0, 0};   // normal cancels
        landmark_table[5] = '{'{100, 100, 100, 100, 100, 150}, 0, 0, 0};   // prev coincides
        landmark_table[6] = '{'{2048, 2048, 0, 0, 4095, 4095}, 0, 0, 0};
        landmark_table[7] = '{'{0, 0, 4095, 0, 0, 4095}, 0, 0, 0};
        landmark_table[8] = '{'{4095, 0, 0, 4095, 4095, 4095}, 0, 0, 0};
        landmark_table[9] = '{'{1, 2, 3, 7, 4094, 4093}, 0, 0, 0};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset values
        foreach (landmark_table[r]) begin
            send_landmark(landmark_table[r].c, first);
            if (landmark_table[r].typed) begin
                if (expected_samples[first].x != landmark_table[r].ex)
                    report_mismatch("typed x", expected_samples[first].x, landmark_table[r].ex);
                if (expected_samples[first].y != landmark_table[r].ey)
                    report_mismatch("typed y", expected_samples[first].y, landmark_table[r].ey);
            end
            sender_gap();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();

        // extremes: longest profile, widest step, largest positive offset, coarsest level
        load_config(15, 255, 15, 3, 4096, 4096);
        for (int r = 3; r < 9; r++) begin
            send_landmark(landmark_table[r].c, first);
            sender_gap();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();
        // zero step, offset of -16, empty width, full-field height, unused indexes
        load_config(0, 0, -16, 0, 0, 8191);
        write_reg(3'd6, 8191);
        write_reg(3'd7, 0);
        for (int r = 4; r < 10; r++) begin
            send_landmark(landmark_table[r].c, first);
            sender_gap();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) load_config(15, 1, -15, 2, 1, 4096);
            else load_config($urandom_range(0, 15), $urandom_range(1, 255),
                             int'($urandom_range(0, 30)) - 15, $urandom_range(0, 3),
                             $urandom_range(1, 4096), $urandom_range(1, 4096));
            if (ph == 1) hold_req = 1;
            for (int n = 0; n < 38; n++) begin
                burst_mode = ($urandom_range(0, 5) == 0);
                random_landmark(c);
                send_landmark(c, first);
                sender_gap();
                if (ph == 2 && n == 19) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    while (expected_samples.size() != 0) @(posedge i_clk);
                end
            end
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            wait_drained();
        end

        $display("landmarks sent: %0d, samples checked: %0d", landmark_count, sample_count);
        $display("covered directed extremes, degenerate normals and random register settings");
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
